// ===== hdl/lwal_pkg.sv =====
// Shared types and constants of the latency window admission limiter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lwal_pkg;

   localparam int unsigned CONC_W     = 16;
   localparam int unsigned MS_W       = 20;
   localparam int unsigned US_CFG_W   = 20;
   localparam int unsigned TO_US_W    = 30;
   localparam int unsigned LAT_W      = 32;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned CNT_W      = 12;
   localparam int unsigned SUM_W      = 44;
   localparam int unsigned RATIO_W    = 16;
   localparam int unsigned PROD_W     = SUM_W + RATIO_W;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [9:0] MS_TO_US = 10'd1000;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam int unsigned DIV_NUM_W = PROD_W + 1;
   localparam int unsigned DIV_DEN_W = CNT_W + 8;
   localparam int unsigned DIV_STEPS = DIV_NUM_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic KIND_REQUEST  = 1'b0;
   localparam logic KIND_RESPONSE = 1'b1;

   localparam logic [1:0] OUTCOME_SUCCESS  = 2'd0;
   localparam logic [1:0] OUTCOME_REJECTED = 2'd1;
   localparam logic [1:0] OUTCOME_FAILURE  = 2'd2;
   localparam logic [1:0] OUTCOME_RESERVED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CONCURRENCY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SAMPLES     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PUNISH_FAILURES = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PUNISH_RATIO    = 3'd7;

   typedef enum logic [1:0] {
      CLS_REQUEST,
      CLS_SUCCESS,
      CLS_FAILURE,
      CLS_SKIP
   } item_class_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SAMPLE,
      BK_ACCUM,
      BK_EVAL,
      BK_MUL,
      BK_START,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      item_class_type     cls;
      logic [CONC_W-1:0]  conc;
      logic [TO_US_W-1:0] timeout_us;
      logic [LAT_W-1:0]   lat_us;
      logic [TIME_W-1:0]  now_us;
   } entry_type;

   typedef struct packed {
      logic [MS_W-1:0]     default_timeout_ms;
      logic [CONC_W-1:0]   conc_limit;
      logic [TO_US_W-1:0]  window_us;
      logic [CNT_W-1:0]    min_samples;
      logic [CNT_W-1:0]    max_samples;
      logic [US_CFG_W-1:0] sample_interval_us;
      logic                punish_failures;
      logic [RATIO_W-1:0]  punish_ratio_q8;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/lwal_front.sv =====
// Front stage: accepts input items, classifies them and forms the timeout in us.
// Depends on lwal_pkg; feeds lwal_queue.
`default_nettype none

module lwal_front
   import lwal_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire logic              in_kind,
   input  wire logic [CONC_W-1:0] in_conc,
   input  wire logic              in_has_timeout,
   input  wire logic [MS_W-1:0]   in_timeout_ms,
   input  wire logic [1:0]        in_outcome,
   input  wire logic [LAT_W-1:0]  in_latency_us,
   input  wire logic [TIME_W-1:0] in_now_us,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output entry_type              push_entry
);

   logic           valid_ff, valid_in;
   entry_type      entry_ff, entry_in;
   item_class_type cls;
   logic [MS_W-1:0] to_ms;
   logic           load;

   always_comb begin
      if (in_kind == KIND_REQUEST) begin
         cls = CLS_REQUEST;
      end else begin
         case (in_outcome) inside
            OUTCOME_SUCCESS:                   cls = CLS_SUCCESS;
            OUTCOME_REJECTED:                  cls = CLS_SKIP;
            OUTCOME_FAILURE, OUTCOME_RESERVED: cls = CLS_FAILURE;
            default:                           cls = CLS_FAILURE;
         endcase
      end
   end

   assign to_ms = in_has_timeout ? in_timeout_ms : cfg.default_timeout_ms;

   always_comb begin
      entry_in.cls        = cls;
      entry_in.conc       = in_conc;
      entry_in.timeout_us = {{(TO_US_W-MS_W){1'b0}}, to_ms} * TO_US_W'(MS_TO_US);
      entry_in.lat_us     = in_latency_us;
      entry_in.now_us     = in_now_us;
   end

   assign in_stall = valid_ff && !push_ready;
   assign load     = in_valid && !in_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// ===== hdl/lwal_queue.sv =====
// Short item queue between the front stage and the back end.
// Depends on lwal_pkg for the entry type and depth.
`default_nettype none

module lwal_queue
   import lwal_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop,
   output entry_type      pop_entry
);

   entry_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != Q_CNT_W'(Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lwal_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on lwal_pkg for widths; used by lwal_back for the window average.
`default_nettype none

module lwal_div
   import lwal_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quo,
   output logic                      rem_nonzero
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done        = done_ff;
   assign quo         = quo_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

`default_nettype wire

// ===== hdl/lwal_back.sv =====
// Back end: admission decision, sampling, window accumulation and average update,
// plus the result register. Depends on lwal_pkg; drives lwal_div.
`default_nettype none

module lwal_back
   import lwal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  pop_valid,
   output logic                       pop,
   input  wire entry_type             pop_entry,
   output logic                       div_start,
   output logic [DIV_NUM_W-1:0]       div_num,
   output logic [DIV_DEN_W-1:0]       div_den,
   input  wire logic                  div_done,
   input  wire logic [DIV_NUM_W-1:0]  div_quo,
   input  wire logic                  div_rem_nonzero,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output logic                       out_admitted,
   output logic                       out_sampled,
   output logic                       out_window_submitted,
   output logic [LAT_W-1:0]           out_average_latency_us
);

   back_state_type state_ff, state_in;

   entry_type         item_ff, item_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] ws_ff, ws_in;
   logic [CNT_W-1:0]  succ_cnt_ff, succ_cnt_in;
   logic [CNT_W-1:0]  fail_cnt_ff, fail_cnt_in;
   logic [SUM_W-1:0]  succ_sum_ff, succ_sum_in;
   logic [SUM_W-1:0]  fail_sum_ff, fail_sum_in;
   logic [LAT_W-1:0]  avg_ff, avg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              admit_ff, admit_in;
   logic              sampled_ff, sampled_in;
   logic              submit_ff, submit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_admit_ff, rsp_sampled_ff, rsp_submit_ff;
   logic [LAT_W-1:0]  rsp_avg_ff;

   logic              out_free;
   logic [TIME_W:0]   diff_last, diff_ws;
   logic [TIME_W-1:0] el_last, span;
   logic              take, win_done;
   logic [CNT_W:0]    total;
   logic              below_min, below_max;
   logic              admit_now;
   logic [SUM_W:0]    succ_add, fail_add;
   logic [LAT_W:0]    dbl;
   logic [DIV_NUM_W:0] q_round;
   logic [LAT_W-1:0]  q_sat, dbl_sat;
   logic              emit;

   assign out_free = !rsp_valid_ff || !out_stall;

   always_comb begin
      diff_last = {1'b0, item_ff.now_us} - {1'b0, last_ff};
      el_last   = diff_last[TIME_W] ? '0 : diff_last[TIME_W-1:0];
      take      = (last_ff == '0) ||
                  (el_last >= {{(TIME_W-US_CFG_W){1'b0}}, cfg.sample_interval_us});
      diff_ws   = {1'b0, item_ff.now_us} - {1'b0, ws_ff};
      span      = diff_ws[TIME_W] ? '0 : diff_ws[TIME_W-1:0];
      win_done  = span >= {{(TIME_W-TO_US_W){1'b0}}, cfg.window_us};
      total     = {1'b0, succ_cnt_ff} + {1'b0, fail_cnt_ff};
      below_min = total < {1'b0, cfg.min_samples};
      below_max = total < {1'b0, cfg.max_samples};
      admit_now = (pop_entry.conc == CONC_W'(1)) ||
                  ((pop_entry.conc <= cfg.conc_limit) &&
                   (avg_ff < {{(LAT_W-TO_US_W){1'b0}}, pop_entry.timeout_us}));
      succ_add  = {1'b0, succ_sum_ff} + {{(SUM_W-LAT_W+1){1'b0}}, item_ff.lat_us};
      fail_add  = {1'b0, fail_sum_ff} + {{(SUM_W-LAT_W+1){1'b0}}, item_ff.lat_us};
      dbl       = {avg_ff, 1'b0};
      dbl_sat   = dbl[LAT_W] ? {LAT_W{1'b1}} : dbl[LAT_W-1:0];
      q_round   = {1'b0, div_quo} + {{DIV_NUM_W{1'b0}}, div_rem_nonzero};
      q_sat     = (q_round[DIV_NUM_W:LAT_W] != '0) ? {LAT_W{1'b1}} : q_round[LAT_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               case (pop_entry.cls) inside
                  CLS_REQUEST, CLS_SKIP: state_in = BK_EMIT;
                  default:               state_in = BK_SAMPLE;
               endcase
            end
         end
         BK_SAMPLE: state_in = take ? BK_ACCUM : BK_EMIT;
         BK_ACCUM:  state_in = BK_EVAL;
         BK_EVAL: begin
            if (below_min || (!win_done && below_max) || succ_cnt_ff == '0) begin
               state_in = BK_EMIT;
            end else begin
               state_in = BK_MUL;
            end
         end
         BK_MUL:   state_in = BK_START;
         BK_START: state_in = BK_DIV;
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      div_start   = 1'b0;
      emit        = 1'b0;
      item_in     = item_ff;
      last_in     = last_ff;
      ws_in       = ws_ff;
      succ_cnt_in = succ_cnt_ff;
      fail_cnt_in = fail_cnt_ff;
      succ_sum_in = succ_sum_ff;
      fail_sum_in = fail_sum_ff;
      avg_in      = avg_ff;
      prod_in     = prod_ff;
      admit_in    = admit_ff;
      sampled_in  = sampled_ff;
      submit_in   = submit_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               pop        = 1'b1;
               item_in    = pop_entry;
               admit_in   = (pop_entry.cls == CLS_REQUEST) && admit_now;
               sampled_in = 1'b0;
               submit_in  = 1'b0;
            end
         end
         BK_SAMPLE: begin
            if (take) begin
               last_in    = item_ff.now_us;
               sampled_in = 1'b1;
            end
         end
         BK_ACCUM: begin
            if (ws_ff == '0) begin
               ws_in = item_ff.now_us;
            end
            if (item_ff.cls == CLS_SUCCESS) begin
               if (succ_cnt_ff != CNT_MAX) begin
                  succ_cnt_in = succ_cnt_ff + 1'b1;
               end
               succ_sum_in = succ_add[SUM_W] ? {SUM_W{1'b1}} : succ_add[SUM_W-1:0];
            end else if (cfg.punish_failures) begin
               if (fail_cnt_ff != CNT_MAX) begin
                  fail_cnt_in = fail_cnt_ff + 1'b1;
               end
               fail_sum_in = fail_add[SUM_W] ? {SUM_W{1'b1}} : fail_add[SUM_W-1:0];
            end
         end
         BK_EVAL: begin
            if (below_min) begin
               if (win_done) begin
                  ws_in       = item_ff.now_us;
                  succ_cnt_in = '0;
                  fail_cnt_in = '0;
                  succ_sum_in = '0;
                  fail_sum_in = '0;
               end
            end else if ((win_done || !below_max) && succ_cnt_ff == '0) begin
               avg_in      = dbl_sat;
               submit_in   = 1'b1;
               ws_in       = item_ff.now_us;
               succ_cnt_in = '0;
               fail_cnt_in = '0;
               succ_sum_in = '0;
               fail_sum_in = '0;
            end
         end
         BK_MUL: begin
            prod_in = fail_sum_ff * cfg.punish_ratio_q8;
         end
         BK_START: begin
            div_start = 1'b1;
         end
         BK_DIV: begin
            if (div_done) begin
               avg_in      = q_sat;
               submit_in   = 1'b1;
               ws_in       = item_ff.now_us;
               succ_cnt_in = '0;
               fail_cnt_in = '0;
               succ_sum_in = '0;
               fail_sum_in = '0;
            end
         end
         BK_EMIT: begin
            emit = out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign div_num = {1'b0, prod_ff} + {{(DIV_NUM_W-SUM_W-8){1'b0}}, succ_sum_ff, 8'b0};
   assign div_den = {succ_cnt_ff, 8'b0};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && out_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         ws_ff        <= '0;
         succ_cnt_ff  <= '0;
         fail_cnt_ff  <= '0;
         succ_sum_ff  <= '0;
         fail_sum_ff  <= '0;
         avg_ff       <= LAT_W'(500);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         ws_ff        <= ws_in;
         succ_cnt_ff  <= succ_cnt_in;
         fail_cnt_ff  <= fail_cnt_in;
         succ_sum_ff  <= succ_sum_in;
         fail_sum_ff  <= fail_sum_in;
         avg_ff       <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      admit_ff   <= admit_in;
      sampled_ff <= sampled_in;
      submit_ff  <= submit_in;
      if (emit) begin
         rsp_admit_ff   <= admit_ff;
         rsp_sampled_ff <= sampled_ff;
         rsp_submit_ff  <= submit_ff;
         rsp_avg_ff     <= avg_ff;
      end
   end

   assign out_valid              = rsp_valid_ff;
   assign out_admitted           = rsp_admit_ff;
   assign out_sampled            = rsp_sampled_ff;
   assign out_window_submitted   = rsp_submit_ff;
   assign out_average_latency_us = rsp_avg_ff;

endmodule

`default_nettype wire

// ===== hdl/latency_window_admission_limiter.sv =====
// Top level of the latency window admission limiter: register file and wiring.
// Depends on lwal_pkg, lwal_front, lwal_queue, lwal_div and lwal_back.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   kind, concurrency, timeout, outcome, latency, time
//   rsp      rsp_valid/rsp_stall   admitted, sampled, window_submitted, average
//   csr      csr_valid/csr_ready   csr_index, csr_wdata (always ready)
//
// One result per item. The back end takes one item at a time: requests and skipped
// responses go straight to emit, unsampled ones through sample, sampled ones
// through sample, accumulate and evaluate, and one closing a window with successes
// also through multiply, start and divide. A front register and a two-item queue
// let input keep flowing while the back end works or the result is stalled.
// Reset is synchronous and restores register and state reset values.
`default_nettype none

module latency_window_admission_limiter
   import lwal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [CONC_W-1:0]     req_current_concurrency,
   input  wire logic                  req_has_request_timeout,
   input  wire logic [MS_W-1:0]       req_request_timeout_ms,
   input  wire logic [1:0]            req_outcome,
   input  wire logic [LAT_W-1:0]      req_latency_us,
   input  wire logic [TIME_W-1:0]     req_now_us,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_admitted,
   output logic                       rsp_sampled,
   output logic                       rsp_window_submitted,
   output logic [LAT_W-1:0]           rsp_average_latency_us,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MS_W-1:0]     default_timeout_ff;
   logic [CONC_W-1:0]   max_conc_ff;
   logic [MS_W-1:0]     window_ms_ff;
   logic [TO_US_W-1:0]  window_us_ff;
   logic [CNT_W-1:0]    min_samples_ff;
   logic [CNT_W-1:0]    max_samples_ff;
   logic [US_CFG_W-1:0] interval_ff;
   logic                punish_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic                csr_write;
   cfg_type             cfg;

   logic                   push_valid, push_ready;
   entry_type              push_entry;
   logic                   pop_valid, pop;
   entry_type              pop_entry;
   logic                   div_start, div_done, div_rem_nonzero;
   logic [DIV_NUM_W-1:0]   div_num, div_quo;
   logic [DIV_DEN_W-1:0]   div_den;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_timeout_ff <= MS_W'(500);
         max_conc_ff        <= CONC_W'(100);
         window_ms_ff       <= MS_W'(1000);
         window_us_ff       <= TO_US_W'(1000000);
         min_samples_ff     <= CNT_W'(100);
         max_samples_ff     <= CNT_W'(200);
         interval_ff        <= US_CFG_W'(100);
         punish_ff          <= 1'b1;
         ratio_ff           <= RATIO_W'(256);
      end else begin
         window_us_ff <= {{(TO_US_W-MS_W){1'b0}}, window_ms_ff} * TO_US_W'(MS_TO_US);
         if (csr_write) begin
            unique case (csr_index)
               CSR_DEFAULT_TIMEOUT: default_timeout_ff <= csr_wdata[MS_W-1:0];
               CSR_MAX_CONCURRENCY: max_conc_ff        <= csr_wdata[CONC_W-1:0];
               CSR_WINDOW_LENGTH:   window_ms_ff       <= csr_wdata[MS_W-1:0];
               CSR_MIN_SAMPLES:     min_samples_ff     <= csr_wdata[CNT_W-1:0];
               CSR_MAX_SAMPLES:     max_samples_ff     <= csr_wdata[CNT_W-1:0];
               CSR_SAMPLE_INTERVAL: interval_ff        <= csr_wdata[US_CFG_W-1:0];
               CSR_PUNISH_FAILURES: punish_ff          <= csr_wdata[0];
               CSR_PUNISH_RATIO:    ratio_ff           <= csr_wdata[RATIO_W-1:0];
               default:             punish_ff          <= punish_ff;
            endcase
         end
      end
   end

   always_comb begin
      cfg.default_timeout_ms = default_timeout_ff;
      cfg.conc_limit         = max_conc_ff;
      cfg.window_us          = window_us_ff;
      cfg.min_samples        = min_samples_ff;
      cfg.max_samples        = max_samples_ff;
      cfg.sample_interval_us = interval_ff;
      cfg.punish_failures    = punish_ff;
      cfg.punish_ratio_q8    = ratio_ff;
   end

   lwal_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_valid),
      .in_stall       (req_stall),
      .in_kind        (req_kind),
      .in_conc        (req_current_concurrency),
      .in_has_timeout (req_has_request_timeout),
      .in_timeout_ms  (req_request_timeout_ms),
      .in_outcome     (req_outcome),
      .in_latency_us  (req_latency_us),
      .in_now_us      (req_now_us),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   lwal_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   lwal_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .num         (div_num),
      .den         (div_den),
      .done        (div_done),
      .quo         (div_quo),
      .rem_nonzero (div_rem_nonzero)
   );

   lwal_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .pop_valid              (pop_valid),
      .pop                    (pop),
      .pop_entry              (pop_entry),
      .div_start              (div_start),
      .div_num                (div_num),
      .div_den                (div_den),
      .div_done               (div_done),
      .div_quo                (div_quo),
      .div_rem_nonzero        (div_rem_nonzero),
      .out_valid              (rsp_valid),
      .out_stall              (rsp_stall),
      .out_admitted           (rsp_admitted),
      .out_sampled            (rsp_sampled),
      .out_window_submitted   (rsp_window_submitted),
      .out_average_latency_us (rsp_average_latency_us)
   );

endmodule

`default_nettype wire

// ===== sim/lwal_checker.sv =====
`timescale 1ns / 1ps
// Checker for the latency window admission limiter: follows register writes and
// the item stream, predicts every result and compares it field by field.
// Depends on lwal_pkg only.

module lwal_checker
   import lwal_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic                  req_kind,
   input  wire logic [CONC_W-1:0]     req_current_concurrency,
   input  wire logic                  req_has_request_timeout,
   input  wire logic [MS_W-1:0]       req_request_timeout_ms,
   input  wire logic [1:0]            req_outcome,
   input  wire logic [LAT_W-1:0]      req_latency_us,
   input  wire logic [TIME_W-1:0]     req_now_us,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic                  rsp_admitted,
   input  wire logic                  rsp_sampled,
   input  wire logic                  rsp_window_submitted,
   input  wire logic [LAT_W-1:0]      rsp_average_latency_us,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                fail_count,
   output int unsigned                pending
);

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [63:0]      AVG_MAX = 64'hFFFF_FFFF;

   typedef struct packed {
      logic             admitted;
      logic             sampled;
      logic             submitted;
      logic [LAT_W-1:0] average_us;
   } verdict_type;

   verdict_type awaited[$];

   logic [MS_W-1:0]     set_default_to_ms;
   logic [CONC_W-1:0]   set_max_conc;
   logic [MS_W-1:0]     set_window_ms;
   logic [CNT_W-1:0]    set_min_samples;
   logic [CNT_W-1:0]    set_max_samples;
   logic [US_CFG_W-1:0] set_interval_us;
   logic                set_punish;
   logic [RATIO_W-1:0]  set_ratio_q8;

   logic [LAT_W-1:0]  avg_us;
   logic [TIME_W-1:0] last_sample_us;
   logic [TIME_W-1:0] window_start_us;
   logic [CNT_W-1:0]  succ_cnt;
   logic [CNT_W-1:0]  fail_cnt;
   logic [SUM_W-1:0]  succ_sum;
   logic [SUM_W-1:0]  fail_sum;

   function automatic logic [TIME_W-1:0] time_since(input logic [TIME_W-1:0] now,
                                                    input logic [TIME_W-1:0] mark);
      return (now >= mark) ? now - mark : '0;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                input logic [LAT_W-1:0] lat);
      logic [SUM_W:0] wide;
      wide = {1'b0, sum} + {{(SUM_W-LAT_W+1){1'b0}}, lat};
      return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
   endfunction

   task automatic open_window(input logic [TIME_W-1:0] now);
      window_start_us = now;
      succ_cnt        = '0;
      fail_cnt        = '0;
      succ_sum        = '0;
      fail_sum        = '0;
   endtask

   task automatic forecast_result(output verdict_type v);
      logic [MS_W-1:0] to_ms;
      logic [63:0]     total;
      logic [63:0]     span;
      logic [63:0]     win_us;
      logic [63:0]     num;
      logic [63:0]     den;
      logic [63:0]     quo;
      v = '0;
      if (req_kind == KIND_REQUEST) begin
         to_ms = req_has_request_timeout ? req_request_timeout_ms : set_default_to_ms;
         v.admitted = (req_current_concurrency == 16'd1) ||
                      (req_current_concurrency <= set_max_conc &&
                       64'(avg_us) < 64'(to_ms) * 64'(MS_TO_US));
      end else if (req_outcome != OUTCOME_REJECTED) begin
         if (last_sample_us == '0 ||
             time_since(req_now_us, last_sample_us) >= TIME_W'(set_interval_us)) begin
            last_sample_us = req_now_us;
            v.sampled = 1'b1;
            if (window_start_us == '0) window_start_us = req_now_us;
            if (req_outcome != OUTCOME_SUCCESS && set_punish) begin
               if (fail_cnt != CNT_MAX) fail_cnt = fail_cnt + 1'b1;
               fail_sum = sat_add(fail_sum, req_latency_us);
            end else if (req_outcome == OUTCOME_SUCCESS) begin
               if (succ_cnt != CNT_MAX) succ_cnt = succ_cnt + 1'b1;
               succ_sum = sat_add(succ_sum, req_latency_us);
            end
            total  = 64'(succ_cnt) + 64'(fail_cnt);
            span   = 64'(time_since(req_now_us, window_start_us));
            win_us = 64'(set_window_ms) * 64'(MS_TO_US);
            if (total < 64'(set_min_samples)) begin
               if (span >= win_us) open_window(req_now_us);
            end else if (span >= win_us || total >= 64'(set_max_samples)) begin
               if (succ_cnt != '0) begin
                  num = 64'(fail_sum) * 64'(set_ratio_q8) + (64'(succ_sum) << 8);
                  den = 64'(succ_cnt) << 8;
                  quo = num / den + (((num % den) != 64'd0) ? 64'd1 : 64'd0);
               end else begin
                  quo = 64'(avg_us) * 64'd2;
               end
               avg_us = (quo > AVG_MAX) ? '1 : quo[LAT_W-1:0];
               open_window(req_now_us);
               v.submitted = 1'b1;
            end
         end
      end
      v.average_us = avg_us;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type fresh;
      if (reset) begin
         set_default_to_ms = 20'd500;
         set_max_conc      = 16'd100;
         set_window_ms     = 20'd1000;
         set_min_samples   = 12'd100;
         set_max_samples   = 12'd200;
         set_interval_us   = 20'd100;
         set_punish        = 1'b1;
         set_ratio_q8      = 16'd256;
         avg_us            = 32'd500;
         last_sample_us    = '0;
         open_window('0);
         awaited.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEFAULT_TIMEOUT: set_default_to_ms = csr_wdata[MS_W-1:0];
               CSR_MAX_CONCURRENCY: set_max_conc      = csr_wdata[CONC_W-1:0];
               CSR_WINDOW_LENGTH:   set_window_ms     = csr_wdata[MS_W-1:0];
               CSR_MIN_SAMPLES:     set_min_samples   = csr_wdata[CNT_W-1:0];
               CSR_MAX_SAMPLES:     set_max_samples   = csr_wdata[CNT_W-1:0];
               CSR_SAMPLE_INTERVAL: set_interval_us   = csr_wdata[US_CFG_W-1:0];
               CSR_PUNISH_FAILURES: set_punish        = csr_wdata[0];
               CSR_PUNISH_RATIO:    set_ratio_q8      = csr_wdata[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $error("result with no item waiting, average_latency_us %0d",
                      rsp_average_latency_us);
               fail_count++;
            end else begin
               want = awaited.pop_front();
               if (rsp_admitted !== want.admitted) begin
                  $error("admitted: expected %0d, actual %0d", want.admitted, rsp_admitted);
                  fail_count++;
               end
               if (rsp_sampled !== want.sampled) begin
                  $error("sampled: expected %0d, actual %0d", want.sampled, rsp_sampled);
                  fail_count++;
               end
               if (rsp_window_submitted !== want.submitted) begin
                  $error("window_submitted: expected %0d, actual %0d",
                         want.submitted, rsp_window_submitted);
                  fail_count++;
               end
               if (rsp_average_latency_us !== want.average_us) begin
                  $error("average_latency_us: expected %0d, actual %0d",
                         want.average_us, rsp_average_latency_us);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            forecast_result(fresh);
            awaited.push_back(fresh);
         end
      end
      pending = awaited.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the latency window admission limiter: clock, reset, item
// stimulus, register writes and verdict. Depends on lwal_pkg, the block and lwal_checker.

module tb;
   import lwal_pkg::*;

   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned DRAIN_LIMIT     = 100000;
   localparam int unsigned ITEMS_PER_PHASE = 125;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_REQUEST;
   logic [CONC_W-1:0]     req_current_concurrency = '0;
   logic                  req_has_request_timeout = 1'b0;
   logic [MS_W-1:0]       req_request_timeout_ms = '0;
   logic [1:0]            req_outcome = OUTCOME_SUCCESS;
   logic [LAT_W-1:0]      req_latency_us = '0;
   logic [TIME_W-1:0]     req_now_us = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_admitted;
   logic                  rsp_sampled;
   logic                  rsp_window_submitted;
   logic [LAT_W-1:0]      rsp_average_latency_us;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEFAULT_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned fail_count;
   int unsigned pending;

   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   int unsigned       hold_asked = 0;
   int unsigned       hold_served = 0;
   int unsigned       hold_left = 0;
   logic [TIME_W-1:0] now_us = '0;

   latency_window_admission_limiter u_top (.*);

   lwal_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic kind, input logic [CONC_W-1:0] conc,
                            input logic has_to, input logic [MS_W-1:0] to_ms,
                            input logic [1:0] outcome, input logic [LAT_W-1:0] lat,
                            input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_kind                <= kind;
      req_current_concurrency <= conc;
      req_has_request_timeout <= has_to;
      req_request_timeout_ms  <= to_ms;
      req_outcome             <= outcome;
      req_latency_us          <= lat;
      req_now_us              <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid, wait for every result, then let the back end go quiet
   task automatic settle(input int unsigned extra);
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] def_to,
                                input logic [CSR_DATA_W-1:0] max_conc,
                                input logic [CSR_DATA_W-1:0] win_ms,
                                input logic [CSR_DATA_W-1:0] min_s,
                                input logic [CSR_DATA_W-1:0] max_s,
                                input logic [CSR_DATA_W-1:0] interval,
                                input logic [CSR_DATA_W-1:0] punish,
                                input logic [CSR_DATA_W-1:0] ratio);
      settle(8);
      write_reg(CSR_DEFAULT_TIMEOUT, def_to);
      write_reg(CSR_MAX_CONCURRENCY, max_conc);
      write_reg(CSR_WINDOW_LENGTH, win_ms);
      write_reg(CSR_MIN_SAMPLES, min_s);
      write_reg(CSR_MAX_SAMPLES, max_s);
      write_reg(CSR_SAMPLE_INTERVAL, interval);
      write_reg(CSR_PUNISH_FAILURES, punish);
      write_reg(CSR_PUNISH_RATIO, ratio);
   endtask

   initial begin : stimulus
      logic [CONC_W-1:0] conc;
      logic [MS_W-1:0]   to_ms;
      logic [LAT_W-1:0]  lat;
      logic [1:0]        oc;
      logic              has_to;
      int unsigned       pick;
      int unsigned       roll;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct <= 75;
      send_item(KIND_REQUEST, 16'd1, 1'b1, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd0);
      send_item(KIND_REQUEST, 16'd100, 1'b0, 20'd1000000, OUTCOME_RESERVED,
                32'hFFFF_FFFF, 48'd0);
      send_item(KIND_REQUEST, 16'd101, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd0);
      send_item(KIND_REQUEST, 16'd0, 1'b1, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd0);
      send_item(KIND_REQUEST, 16'hFFFF, 1'b1, 20'd1000000, OUTCOME_FAILURE, 32'd0, 48'd0);

      load_settings(20'd0, 20'd65535, 20'd1, 20'd1, 20'd2, 20'd0, 20'd1, 20'd65535);
      send_item(KIND_REQUEST, 16'd2, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd0);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_REJECTED, 32'd9, 48'd10);
      // time zero keeps the sample and window marks unset
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd0);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_FAILURE, 32'hFFFF_FFFF, 48'd100);
      send_item(KIND_REQUEST, 16'hFFFF, 1'b1, 20'd1000000, OUTCOME_SUCCESS, 32'd0, 48'd100);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_RESERVED, 32'd5, 48'd200);
      // time running backwards
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_RESERVED, 32'd6, 48'd150);

      load_settings(20'd1000000, 20'd0, 20'd1000000, 20'd1, 20'd1, 20'd1000000, 20'd1, 20'd0);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd7, 48'd1000);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd7, 48'd1001150);
      send_item(KIND_REQUEST, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd0, 48'd1001150);

      // failures left out of the window, empty window allowed to close
      load_settings(20'd500, 20'd100, 20'd1, 20'd0, 20'd4095, 20'd0, 20'd0, 20'd256);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_FAILURE, 32'd100, 48'd1001200);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_FAILURE, 32'd100, 48'd1002500);

      // minimum above maximum
      load_settings(20'd500, 20'd65535, 20'd1000000, 20'd3, 20'd1, 20'd0, 20'd1, 20'd512);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd100, 48'd1002600);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_FAILURE, 32'd300, 48'd1002700);
      send_item(KIND_RESPONSE, 16'd0, 1'b0, 20'd0, OUTCOME_SUCCESS, 32'd4095, 48'd1002800);
      send_item(KIND_REQUEST, 16'd3, 1'b1, 20'd2, OUTCOME_SUCCESS, 32'd0, 48'd1002800);
      send_item(KIND_REQUEST, 16'd3, 1'b1, 20'd3, OUTCOME_SUCCESS, 32'd0, 48'd1002800);
      now_us = 48'd1002800;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            3: load_settings(20'd0, 20'd0, 20'd1, 20'd1, 20'd1, 20'd0, 20'd0, 20'd0);
            5: load_settings(20'd1000000, 20'd65535, 20'd1000000, 20'd4095, 20'd4095,
                             20'd1000000, 20'd1, 20'd65535);
            default: load_settings(CSR_DATA_W'($urandom_range(40)),
                                   CSR_DATA_W'($urandom_range(200)),
                                   CSR_DATA_W'($urandom_range(8, 1)),
                                   CSR_DATA_W'($urandom_range(6, 1)),
                                   CSR_DATA_W'($urandom_range(12, 1)),
                                   CSR_DATA_W'($urandom_range(150)),
                                   CSR_DATA_W'($urandom_range(1)),
                                   (phase == 1) ? 20'd65535
                                                : CSR_DATA_W'($urandom_range(1024)));
         endcase
         if (phase < 2) begin
            send_idle_pct = 24;
            recv_idle_pct <= 75;
         end else if (phase < 4) begin
            send_idle_pct = 75;
            recv_idle_pct <= 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         if (phase == 5) now_us = 48'hFFFF_FF00_0000;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 4 && n == 20) hold_asked <= hold_asked + 1;
            now_us = now_us + TIME_W'($urandom_range(200));
            if ($urandom_range(19) == 0) now_us = now_us + TIME_W'($urandom_range(10000, 1000));
            roll = $urandom_range(99);
            if (roll < 15) conc = 16'd1;
            else if (roll < 60) conc = CONC_W'($urandom_range(220));
            else conc = CONC_W'($urandom);
            to_ms  = ($urandom_range(9) < 7) ? MS_W'($urandom_range(60))
                                              : MS_W'($urandom_range(1000000));
            lat    = ($urandom_range(7) == 0) ? $urandom : LAT_W'($urandom_range(50000));
            has_to = 1'($urandom_range(1));
            roll   = $urandom_range(9);
            if (roll < 6) oc = OUTCOME_SUCCESS;
            else if (roll < 9) oc = OUTCOME_FAILURE;
            else oc = OUTCOME_RESERVED;
            pick = $urandom_range(99);
            if (pick < 40)
               send_item(KIND_REQUEST, conc, has_to, to_ms, 2'($urandom_range(3)),
                         $urandom, now_us);
            else if (pick < 90)
               send_item(KIND_RESPONSE, conc, has_to, to_ms, oc, lat, now_us);
            else if (pick < 95)
               send_item(KIND_RESPONSE, conc, has_to, to_ms, OUTCOME_REJECTED, lat, now_us);
            else
               send_item(KIND_RESPONSE, conc, has_to, to_ms, oc, lat,
                         now_us - TIME_W'($urandom_range(500)));
         end
      end

      settle(100);
      @(negedge clock);
      if (pending != 0) $error("%0d items left without a result", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lwal_pkg.sv
hdl/lwal_front.sv
hdl/lwal_queue.sv
hdl/lwal_div.sv
hdl/lwal_back.sv
hdl/latency_window_admission_limiter.sv
sim/lwal_checker.sv
sim/tb.sv
